FILE: src/cnms_pkg.sv
package cnms_pkg;

    localparam int unsigned MS_PER_MIN = 60000;
    localparam int SEARCH_MINUTES_DEF = 527040;

    localparam logic [48:0] MIN_MS       = 49'd60000;
    localparam logic [48:0] HOUR_MS      = 49'd3600000;
    localparam logic [48:0] DAY_MS       = 49'd86400000;
    localparam logic [48:0] MONTH28_MS   = 49'd2419200000;
    localparam logic [48:0] MONTH29_MS   = 49'd2505600000;
    localparam logic [48:0] MONTH30_MS   = 49'd2592000000;
    localparam logic [48:0] MONTH31_MS   = 49'd2678400000;
    localparam logic [48:0] YEAR_MS      = 49'd31536000000;
    localparam logic [48:0] LEAP_YEAR_MS = 49'd31622400000;

    typedef enum logic [2:0]
    {
        REG_MINUTE  = 3'd0,
        REG_HOUR    = 3'd1,
        REG_DAY     = 3'd2,
        REG_MONTH   = 3'd3,
        REG_WEEKDAY = 3'd4,
        REG_DAY_ANY = 3'd5,
        REG_WDAY_ANY = 3'd6
    } reg_idx_t;

    typedef struct packed
    {
        logic [59:0] minute_mask;
        logic [23:0] hour_mask;
        logic [30:0] day_mask;
        logic [11:0] month_mask;
        logic [6:0]  weekday_mask;
        logic        day_any;
        logic        weekday_any;
    } cfg_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] r;
        begin
            case (month) inside
                4'd2: r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
                default: r = 5'd31;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: src/cron_next_match_search.sv
// cron next-match search
// input channel: in_valid/in_ready with after_ms (signed unix ms, negative
// clamped to zero). output channel: out_valid/out_ready with found and tick_ms.
// config port: cfg_we, cfg_index, cfg_data; write only while idle.
// operation: the start time plus one minute is walked down with one shared
// compare/subtract step per cycle: year by year from 1970, then by month,
// day, hour and minute, which gives the calendar of the first candidate
// minute (up to about 8920 year steps for the largest dates). the search
// then steps one candidate minute per cycle with an incrementing calendar,
// up to SEARCH_MINUTES candidates.
// one item at a time: the next input can be taken in the cycle after the
// result transfer.
// in_ready is low from acceptance until the result transfer completes.
// a stalled receiver holds the result in the output register.
// reset returns every mask to all ones and both wildcards set, and idles.
module cron_next_match_search
#(
    parameter int SEARCH_MINUTES = cnms_pkg::SEARCH_MINUTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [48:0] after_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [48:0] tick_ms,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [59:0] cfg_data
);

    localparam int CNT_W = $clog2(SEARCH_MINUTES + 1);

    typedef enum logic [7:0]
    {
        S_IDLE  = 8'b00000001,
        S_YEAR  = 8'b00000010,
        S_MONTH = 8'b00000100,
        S_DAY   = 8'b00001000,
        S_HOUR  = 8'b00010000,
        S_MIN   = 8'b00100000,
        S_SRCH  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    cnms_pkg::cfg_t cfg;
    state_t state_reg;
    logic [48:0] rem_reg;
    logic [1:0]  y4_reg;
    logic [6:0]  y100_reg;
    logic [8:0]  y400_reg;
    logic [3:0]  month_reg;
    logic [4:0]  mday_reg;
    logic [2:0]  wday_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic        found_reg;
    logic [48:0] tick_reg;

    logic        leap;
    logic [4:0]  mlen;
    logic        day_ok;
    logic        match;
    logic [48:0] start_ms;
    logic [48:0] step;
    logic [49:0] diff;
    logic        borrow;
    logic [6:0]  y100_inc;
    logic [8:0]  y400_inc;

    function automatic logic [2:0] wday_add(input logic [2:0] w, input logic [1:0] k);
        logic [3:0] s;
        begin
            s = {1'b0, w} + {2'b0, k};
            return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
        end
    endfunction

    cnms_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign leap = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
    assign mlen = cnms_pkg::month_days(month_reg, leap);
    assign y100_inc = (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
    assign y400_inc = (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
    assign start_ms = (after_ms[48] ? 49'd0 : after_ms) + cnms_pkg::MIN_MS;

    always_comb
    begin
        unique case (state_reg)
            S_YEAR:  step = leap ? cnms_pkg::LEAP_YEAR_MS : cnms_pkg::YEAR_MS;
            S_MONTH:
            begin
                case (mlen)
                    5'd28:   step = cnms_pkg::MONTH28_MS;
                    5'd29:   step = cnms_pkg::MONTH29_MS;
                    5'd30:   step = cnms_pkg::MONTH30_MS;
                    default: step = cnms_pkg::MONTH31_MS;
                endcase
            end
            S_DAY:   step = cnms_pkg::DAY_MS;
            S_HOUR:  step = cnms_pkg::HOUR_MS;
            default: step = cnms_pkg::MIN_MS;
        endcase
    end

    assign diff = {1'b0, rem_reg} - {1'b0, step};
    assign borrow = diff[49];

    always_comb
    begin
        logic dm;
        logic wm;
        dm = cfg.day_mask[mday_reg - 5'd1];
        wm = cfg.weekday_mask[wday_reg];
        if (cfg.day_any && cfg.weekday_any)
        begin
            day_ok = 1'b1;
        end
        else if (cfg.day_any)
        begin
            day_ok = wm;
        end
        else if (cfg.weekday_any)
        begin
            day_ok = dm;
        end
        else
        begin
            day_ok = dm || wm;
        end
    end

    assign match = cfg.minute_mask[min_reg] && cfg.hour_mask[hour_reg]
                 && cfg.month_mask[month_reg - 4'd1] && day_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rem_reg <= '0;
            y4_reg <= '0;
            y100_reg <= '0;
            y400_reg <= '0;
            month_reg <= 4'd1;
            mday_reg <= 5'd1;
            wday_reg <= '0;
            min_reg <= '0;
            hour_reg <= '0;
            cnt_reg <= '0;
            found_reg <= 1'b0;
            tick_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        rem_reg <= start_ms;
                        tick_reg <= start_ms;
                        y4_reg <= 2'd2;
                        y100_reg <= 7'd70;
                        y400_reg <= 9'd370;
                        month_reg <= 4'd1;
                        mday_reg <= 5'd1;
                        wday_reg <= 3'd4;
                        hour_reg <= '0;
                        min_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_YEAR;
                    end
                end
                S_YEAR:
                begin
                    if (!borrow)
                    begin
                        rem_reg <= diff[48:0];
                        y4_reg <= y4_reg + 2'd1;
                        y100_reg <= y100_inc;
                        y400_reg <= y400_inc;
                        wday_reg <= wday_add(wday_reg, leap ? 2'd2 : 2'd1);
                    end
                    else
                    begin
                        state_reg <= S_MONTH;
                    end
                end
                S_MONTH:
                begin
                    if (!borrow)
                    begin
                        rem_reg <= diff[48:0];
                        month_reg <= month_reg + 4'd1;
                        wday_reg <= wday_add(wday_reg, 2'(mlen - 5'd28));
                    end
                    else
                    begin
                        state_reg <= S_DAY;
                    end
                end
                S_DAY:
                begin
                    if (!borrow)
                    begin
                        rem_reg <= diff[48:0];
                        mday_reg <= mday_reg + 5'd1;
                        wday_reg <= wday_add(wday_reg, 2'd1);
                    end
                    else
                    begin
                        state_reg <= S_HOUR;
                    end
                end
                S_HOUR:
                begin
                    if (!borrow)
                    begin
                        rem_reg <= diff[48:0];
                        hour_reg <= hour_reg + 5'd1;
                    end
                    else
                    begin
                        state_reg <= S_MIN;
                    end
                end
                S_MIN:
                begin
                    if (!borrow)
                    begin
                        rem_reg <= diff[48:0];
                        min_reg <= min_reg + 6'd1;
                    end
                    else
                    begin
                        tick_reg <= tick_reg - rem_reg;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (match)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (cnt_reg == CNT_W'(SEARCH_MINUTES - 1))
                    begin
                        found_reg <= 1'b0;
                        tick_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        tick_reg <= tick_reg + cnms_pkg::MIN_MS;
                        if (min_reg != 6'd59)
                        begin
                            min_reg <= min_reg + 6'd1;
                        end
                        else
                        begin
                            min_reg <= '0;
                            if (hour_reg != 5'd23)
                            begin
                                hour_reg <= hour_reg + 5'd1;
                            end
                            else
                            begin
                                hour_reg <= '0;
                                wday_reg <= (wday_reg == 3'd6) ? 3'd0 : wday_reg + 3'd1;
                                if (mday_reg != mlen)
                                begin
                                    mday_reg <= mday_reg + 5'd1;
                                end
                                else
                                begin
                                    mday_reg <= 5'd1;
                                    if (month_reg != 4'd12)
                                    begin
                                        month_reg <= month_reg + 4'd1;
                                    end
                                    else
                                    begin
                                        month_reg <= 4'd1;
                                        y4_reg <= y4_reg + 2'd1;
                                        y100_reg <= y100_inc;
                                        y400_reg <= y400_inc;
                                    end
                                end
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign found = found_reg;
    assign tick_ms = tick_reg;

`ifndef SYNTH
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIN && borrow) |=> (state_reg == S_SRCH))
        else $error("calendar walk did not finish");
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (tick_ms == '0))
        else $error("not found with nonzero tick");
    a_cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (cnt_reg < CNT_W'(SEARCH_MINUTES)))
        else $error("search count overrun");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(tick_ms)))
        else $error("result dropped under stall");
`endif

endmodule

FILE: src/cnms_cfg.sv
module cnms_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [59:0]         cfg_data,
    output cnms_pkg::cfg_t      cfg
);

    cnms_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cnms_pkg::REG_MINUTE:   cfg_reg.minute_mask <= cfg_data;
                cnms_pkg::REG_HOUR:     cfg_reg.hour_mask <= cfg_data[23:0];
                cnms_pkg::REG_DAY:      cfg_reg.day_mask <= cfg_data[30:0];
                cnms_pkg::REG_MONTH:    cfg_reg.month_mask <= cfg_data[11:0];
                cnms_pkg::REG_WEEKDAY:  cfg_reg.weekday_mask <= cfg_data[6:0];
                cnms_pkg::REG_DAY_ANY:  cfg_reg.day_any <= cfg_data[0];
                cnms_pkg::REG_WDAY_ANY: cfg_reg.weekday_any <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
